// File: rtl/nca_pkg.sv
package nca_pkg;

	localparam int COORD_BITS     = 24;
	localparam int CORE_IDX_BITS  = 6;
	localparam int DIFF_BITS      = COORD_BITS + 1;
	localparam int SQ_BITS        = 2 * DIFF_BITS;
	// Three squares of at most 2^48 each still fit in the 50-bit distance.
	localparam int DIST_BITS      = SQ_BITS;
	localparam int HIT_BITS       = 32;
	localparam int NV_BITS        = 7;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;
	localparam int MAX_VOXELS_DEF = 64;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic [NV_BITS-1:0] NV_RESET       = NV_BITS'(1);
	localparam logic [0:0]         REG_NUM_VOXELS = 1'b0;

	typedef enum logic [1:0] {
		ACT_LOAD     = 2'd0,
		ACT_CLASSIFY = 2'd1,
		ACT_CLEAR    = 2'd2
	} action_t;

	typedef struct packed {
		action_t                       action;
		logic [CORE_IDX_BITS-1:0]      core_index;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic signed [COORD_BITS-1:0]  coord_z;
	} item_t;

	typedef struct packed {
		logic [CORE_IDX_BITS-1:0] voxel_index;
		logic [DIST_BITS-1:0]     best_distance;
		logic [HIT_BITS-1:0]      hit_count;
	} result_t;

	typedef struct packed {
		logic accept;
		logic core_we;
		logic scan;
		logic cnt_rd;
		logic cnt_wr;
		logic sweep;
		logic emit_load;
		logic emit_zero;
		logic emit_hit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic sweep_end;
		logic scan_done;
	} dp_sts_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_CNT_RD = 7'b0001000,
		ST_CNT_WR = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_INIT   = 7'b1000000
	} state_t;

endpackage

// File: rtl/nca_ram.sv
module nca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/nca_ctrl.sv
module nca_ctrl
	import nca_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  action_t action,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (action)
						ACT_LOAD: begin
							cmd.core_we   = 1'b1;
							cmd.emit_load = 1'b1;
						end
						ACT_CLASSIFY: begin
							state_d = ST_SCAN;
						end
						ACT_CLEAR: begin
							state_d = ST_CLEAR;
						end
						default: begin
							cmd.emit_zero = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.scan_done) begin
					state_d = ST_CNT_RD;
				end
			end
			ST_CNT_RD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cmd.cnt_wr   = 1'b1;
				cmd.emit_hit = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_end) begin
					cmd.emit_zero = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_INIT: begin
				// Same sweep as a clear transaction, but no result goes out.
				cmd.sweep = 1'b1;
				if (sts.sweep_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/nca_dp.sv
module nca_dp
	import nca_pkg::*;
#(
	parameter int MAX_VOXELS = MAX_VOXELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              item,
	input  logic [NV_BITS-1:0] num_voxels,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output result_t            result,
	output logic               result_valid
);

	localparam int IW = (MAX_VOXELS > 1) ? $clog2(MAX_VOXELS) : 1;
	localparam int EW = (IW > NV_BITS) ? IW + 1 : NV_BITS + 1;
	localparam int XW = (IW > CORE_IDX_BITS) ? IW + 1 : CORE_IDX_BITS + 1;
	localparam int CORE_BITS = 3 * COORD_BITS;

	function automatic logic [DIFF_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [DIFF_BITS-1:0] d;
		d = DIFF_BITS'(a) - DIFF_BITS'(b);
		return d[DIFF_BITS-1] ? unsigned'(-d) : unsigned'(d);
	endfunction

	// Search limit: zero counts as one core, anything past the table as the whole table.
	logic [EW-1:0] nv_e, lim_e, last_e;
	logic [IW-1:0] scan_last, sweep_last;

	assign nv_e       = EW'(num_voxels);
	assign lim_e      = EW'(MAX_VOXELS - 1);
	assign sweep_last = IW'(MAX_VOXELS - 1);

	always_comb begin
		if (nv_e == '0) begin
			last_e = '0;
		end else if ((nv_e - EW'(1)) > lim_e) begin
			last_e = lim_e;
		end else begin
			last_e = nv_e - EW'(1);
		end
	end

	assign scan_last = last_e[IW-1:0];

	logic [IW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.accept) begin
			addr_q <= '0;
		end else if (cmd.scan || cmd.sweep) begin
			addr_q <= addr_q + IW'(1);
		end
	end

	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= item.coord_x;
			py_q <= item.coord_y;
			pz_q <= item.coord_z;
		end
	end

	logic                 in_range;
	logic [CORE_BITS-1:0] core_rd;

	assign in_range = XW'(item.core_index) < XW'(MAX_VOXELS);

	nca_ram #(
		.WIDTH (CORE_BITS),
		.DEPTH (MAX_VOXELS)
	) u_core_ram (
		.clk   (clk),
		.we    (cmd.core_we && in_range),
		.waddr (IW'(item.core_index)),
		.wdata ({item.coord_x, item.coord_y, item.coord_z}),
		.re    (cmd.scan),
		.raddr (addr_q),
		.rdata (core_rd)
	);

	logic signed [COORD_BITS-1:0] cx, cy, cz;

	assign cx = core_rd[3*COORD_BITS-1 -: COORD_BITS];
	assign cy = core_rd[2*COORD_BITS-1 -: COORD_BITS];
	assign cz = core_rd[COORD_BITS-1:0];

	// Distance pipeline: RAM read, absolute differences, squares, sum, compare.
	logic                 vld_s1, vld_s2, vld_s3, vld_s4, done_q;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic [IW-1:0]        idx_s1, idx_s2, idx_s3, idx_s4;
	logic [DIFF_BITS-1:0] diff_s2 [3];
	logic [SQ_BITS-1:0]   sq_s3 [3];
	logic [DIST_BITS-1:0] dist_s4;
	logic [DIST_BITS-1:0] best_d_q;
	logic [IW-1:0]        best_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done_q <= vld_s4 && last_s4;
		end
	end

	always_ff @(posedge clk) begin
		last_s1    <= cmd.scan && sts.scan_end;
		idx_s1     <= addr_q;
		last_s2    <= last_s1;
		idx_s2     <= idx_s1;
		diff_s2[0] <= abs_diff(px_q, cx);
		diff_s2[1] <= abs_diff(py_q, cy);
		diff_s2[2] <= abs_diff(pz_q, cz);
		last_s3    <= last_s2;
		idx_s3     <= idx_s2;
		for (int a = 0; a < 3; a++) begin
			sq_s3[a] <= diff_s2[a] * diff_s2[a];
		end
		last_s4    <= last_s3;
		idx_s4     <= idx_s3;
		dist_s4    <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		// Strict less-than keeps the lower index on a tie.
		if (vld_s4 && ((idx_s4 == '0) || (dist_s4 < best_d_q))) begin
			best_d_q <= dist_s4;
			best_i_q <= idx_s4;
		end
	end

	assign sts.scan_end  = (addr_q == scan_last);
	assign sts.sweep_end = (addr_q == sweep_last);
	assign sts.scan_done = done_q;

	logic [COUNT_BITS-1:0] cnt_rd, cnt_inc;

	assign cnt_inc = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_BITS'(1);

	nca_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_VOXELS)
	) u_count_ram (
		.clk   (clk),
		.we    (cmd.cnt_wr || cmd.sweep),
		.waddr (cmd.cnt_wr ? best_i_q : addr_q),
		.wdata (cmd.cnt_wr ? cnt_inc : '0),
		.re    (cmd.cnt_rd),
		.raddr (best_i_q),
		.rdata (cnt_rd)
	);

	result_t result_q;
	logic    result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_load || cmd.emit_zero || cmd.emit_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			result_q <= {item.core_index, {(DIST_BITS + HIT_BITS){1'b0}}};
		end else if (cmd.emit_hit) begin
			result_q.voxel_index   <= CORE_IDX_BITS'(best_i_q);
			result_q.best_distance <= best_d_q;
			result_q.hit_count     <= HIT_BITS'(cnt_inc);
		end else if (cmd.emit_zero) begin
			result_q <= '0;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

// File: rtl/nearest_core_voxel_assign.sv
// Nearest voxel core assignment.
// Transactions enter on start/item and are taken at a clock edge where start is
// high and busy is low. Every transaction yields one result on result, marked by
// result_valid for exactly one cycle; the receiver has no way to hold it off.
// A load writes one core and answers in the cycle after acceptance. A classify
// walks the first num_voxels cores (at least one, at most MAX_VOXELS) through a
// five-stage distance pipeline, one core per cycle from the core table RAM,
// then reads and rewrites the winner's hit count; busy stays high until its result
// goes out, so no new transaction is taken before then. A clear sweeps the
// hit count RAM one entry per cycle, then answers.
// An unused action code answers an all-zero result in the next cycle.
// num_voxels is written over the APB port (byte address 0); the user must do so
// only while busy is low, which the block does not enforce. After reset
// num_voxels is 1 and busy stays high while the hit counts are cleared; the core
// table holds no defined contents until each entry is loaded.
module nearest_core_voxel_assign
	import nca_pkg::*;
#(
	parameter int MAX_VOXELS = MAX_VOXELS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     start,
	input  item_t                    item,
	output logic                     busy,
	output result_t                  result,
	output logic                     result_valid
);

	logic [NV_BITS-1:0] num_voxels_q;
	logic [0:0]         reg_sel;

	assign reg_sel = paddr[APB_ADDR_BITS-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == REG_NUM_VOXELS) ? APB_DATA_BITS'(num_voxels_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_voxels_q <= NV_RESET;
		end else if (psel && penable && pwrite && pready && (reg_sel == REG_NUM_VOXELS)) begin
			num_voxels_q <= pwdata[NV_BITS-1:0];
		end
	end

	dp_cmd_t cmd;
	dp_sts_t sts;

	nca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	nca_dp #(
		.MAX_VOXELS (MAX_VOXELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.num_voxels   (num_voxels_q),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result),
		.result_valid (result_valid)
	);

	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.action == ACT_LOAD |=>
			result_valid && result.voxel_index == $past(item.core_index) &&
			result.hit_count == '0)
		else $error("load transaction did not echo its index");

	a_classify_holds: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.action == ACT_CLASSIFY |=> busy && !result_valid)
		else $error("classify transaction did not start a search");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_count == '0 |-> result.best_distance == '0)
		else $error("distance reported without a hit");

endmodule
